FILE: rtl/cbm_pkg.sv
//------------------------------------------------------------------------------
// Color blob moment accumulator package
// Shared widths, register indexes, verdict codes, reset values and the
// payload and sideband structures used across the block.
//------------------------------------------------------------------------------
package cbm_pkg;

	// Field widths.
	localparam int unsigned COL_W      = 10;
	localparam int unsigned ROW_W      = 9;
	localparam int unsigned CH_W       = 8;
	localparam int unsigned CNT_W      = 19;
	localparam int unsigned SUM_W      = 28;
	localparam int unsigned SQ_W       = 37;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 19;

	// Image extent; pixels at or beyond it are never kept.
	localparam int unsigned IMAGE_WIDTH  = 640;
	localparam int unsigned IMAGE_HEIGHT = 512;

	// Trapezoid edges: left = trunc(426*(190-row)/190), right = floor(354*(190+row)/190).
	localparam int unsigned TRAP_DEN       = 190;
	localparam int unsigned TRAP_LEFT_NUM  = 426;
	localparam int unsigned TRAP_RIGHT_NUM = 354;

	// Yellow test weights: 10*blue < 7*red and 10*blue < 7*green.
	localparam int unsigned YEL_BLUE_WT = 10;
	localparam int unsigned YEL_RG_WT   = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RED_FLOOR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_YELLOW_FLOOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL    = 3'd6;

	// Configuration reset values.
	localparam logic [COL_W-1:0]  ROI_LEFT_RST     = 10'd0;
	localparam logic [ROW_W-1:0]  ROI_TOP_RST      = 9'd332;
	localparam logic [COL_W-1:0]  ROI_WIDTH_RST    = 10'd639;
	localparam logic [COL_W-1:0]  ROI_HEIGHT_RST   = 10'd115;
	localparam logic [CH_W-1:0]   RED_FLOOR_RST    = 8'd150;
	localparam logic [CH_W-1:0]   YELLOW_FLOOR_RST = 8'd100;
	localparam logic [CNT_W-1:0]  MIN_TOTAL_RST    = 19'd20;

	// Verdict codes.
	localparam logic [1:0] VERDICT_NONE   = 2'd0;
	localparam logic [1:0] VERDICT_RED    = 2'd1;
	localparam logic [1:0] VERDICT_YELLOW = 2'd2;

	// Arithmetic types.
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [SQ_W-1:0]   sq_t;
	typedef logic [COL_W:0]    bound_t;
	typedef logic [19:0]       edge_t;
	typedef logic [11:0]       wchan_t;

	// Input pixel payload.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [CH_W-1:0]  pixel_red;
		logic [CH_W-1:0]  pixel_green;
		logic [CH_W-1:0]  pixel_blue;
		logic             frame_end;
	} pix_t;

	// Result payload.
	typedef struct packed {
		logic [1:0] verdict;
		cnt_t       red_count;
		sum_t       red_sum_x;
		sum_t       red_sum_y;
		sq_t        red_sum_xx;
		sq_t        red_sum_yy;
		cnt_t       yellow_count;
		sum_t       yellow_sum_x;
		sum_t       yellow_sum_y;
		sq_t        yellow_sum_xx;
		sq_t        yellow_sum_yy;
	} res_t;

	// Region and color thresholds seen by the pixel filter.
	typedef struct packed {
		logic [COL_W-1:0] roi_left;
		logic [ROW_W-1:0] roi_top;
		logic [COL_W-1:0] roi_width;
		logic [COL_W-1:0] roi_height;
		logic [CH_W-1:0]  red_floor;
		logic [CH_W-1:0]  yellow_floor;
	} cfg_t;

	// Class decisions of one filtered pixel.
	typedef struct packed {
		logic red;
		logic yellow;
		logic last;
	} hit_t;

	// Coordinates and their squares of one filtered pixel.
	typedef struct packed {
		logic [COL_W-1:0]   x;
		logic [ROW_W-1:0]   y;
		logic [2*COL_W-1:0] xx;
		logic [2*ROW_W-1:0] yy;
	} sample_t;

	// Moment accumulators of one class.
	typedef struct packed {
		cnt_t tally;
		sum_t col_sum;
		sum_t row_sum;
		sq_t  col_sq_sum;
		sq_t  row_sq_sum;
	} acc_t;

endpackage

FILE: rtl/cbm_pix_if.sv
//------------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one pixel per transfer.
//------------------------------------------------------------------------------
interface cbm_pix_if;
	logic          valid;
	logic          ready;
	cbm_pkg::pix_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cbm_res_if.sv
//------------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one frame result per transfer.
//------------------------------------------------------------------------------
interface cbm_res_if;
	logic          valid;
	logic          ready;
	cbm_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cbm_pixel_filter.sv
//------------------------------------------------------------------------------
// Pixel filter
// Input register and classification stage: region and trapezoid clipping,
// red and yellow tests, and coordinate squares.
//------------------------------------------------------------------------------
module cbm_pixel_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	cbm_pix_if.sink              pix,
	input  cbm_pkg::cfg_t        cfg,
	input  logic                 adv,
	output logic                 valid_s2,
	output cbm_pkg::hit_t        hit_s2,
	output cbm_pkg::sample_t     sample_s2
);

	logic          valid_s1;
	cbm_pkg::pix_t pix_s1;
	logic          s1_free;
	logic          s2_free;

	logic                 in_image;
	logic                 row_ok;
	logic                 col_ok;
	logic                 left_ok;
	logic                 right_ok;
	logic                 kept;
	logic                 red_ok;
	logic                 yellow_ok;
	cbm_pkg::bound_t      row_end;
	cbm_pkg::bound_t      col_end;
	cbm_pkg::edge_t       col_scaled;
	cbm_pkg::edge_t       left_lim;
	cbm_pkg::edge_t       right_lim;
	cbm_pkg::wchan_t      blue_w;
	cbm_pkg::hit_t        hit_d;
	cbm_pkg::sample_t     sample_d;

	// Stage occupancy: a stage takes a new item when it is empty or drains.
	assign s2_free   = !valid_s2 || adv;
	assign s1_free   = !valid_s1 || s2_free;
	assign pix.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= pix.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (s1_free && pix.valid) begin
			pix_s1 <= pix.data;
		end
	end

	// Region rectangle and trapezoid. With x integer, x >= floor(n/190) is
	// 190*(x+1) > n and x < floor(n/190) is 190*(x+1) <= n, so no divide.
	// From row 190 on the left edge is zero or negative and never clips.
	always_comb begin
		in_image = (32'(pix_s1.col) < cbm_pkg::IMAGE_WIDTH)
			&& (32'(pix_s1.row) < cbm_pkg::IMAGE_HEIGHT);
		row_end = cbm_pkg::bound_t'(cfg.roi_top) + cbm_pkg::bound_t'(cfg.roi_height);
		col_end = cbm_pkg::bound_t'(cfg.roi_left) + cbm_pkg::bound_t'(cfg.roi_width);
		row_ok = (pix_s1.row >= cfg.roi_top)
			&& (cbm_pkg::bound_t'(pix_s1.row) < row_end);
		col_ok = (pix_s1.col >= cfg.roi_left)
			&& (cbm_pkg::bound_t'(pix_s1.col) < col_end);
		col_scaled = (cbm_pkg::edge_t'(pix_s1.col) + cbm_pkg::edge_t'(1))
			* cbm_pkg::edge_t'(cbm_pkg::TRAP_DEN);
		left_lim = (cbm_pkg::edge_t'(cbm_pkg::TRAP_DEN) - cbm_pkg::edge_t'(pix_s1.row))
			* cbm_pkg::edge_t'(cbm_pkg::TRAP_LEFT_NUM);
		right_lim = (cbm_pkg::edge_t'(cbm_pkg::TRAP_DEN) + cbm_pkg::edge_t'(pix_s1.row))
			* cbm_pkg::edge_t'(cbm_pkg::TRAP_RIGHT_NUM);
		left_ok = (cbm_pkg::edge_t'(pix_s1.row) >= cbm_pkg::edge_t'(cbm_pkg::TRAP_DEN))
			|| (col_scaled > left_lim);
		right_ok = col_scaled <= right_lim;
		kept = in_image && row_ok && col_ok && left_ok && right_ok;
	end

	// Color tests, exact in integers.
	always_comb begin
		blue_w = cbm_pkg::wchan_t'(pix_s1.pixel_blue) * cbm_pkg::wchan_t'(cbm_pkg::YEL_BLUE_WT);
		red_ok = ({1'b0, pix_s1.pixel_red} > {pix_s1.pixel_green, 1'b0})
			&& ({1'b0, pix_s1.pixel_red} > {pix_s1.pixel_blue, 1'b0})
			&& (pix_s1.pixel_red > cfg.red_floor);
		yellow_ok = (pix_s1.pixel_red > cfg.yellow_floor)
			&& (pix_s1.pixel_green > cfg.yellow_floor)
			&& (blue_w < cbm_pkg::wchan_t'(pix_s1.pixel_red)
				* cbm_pkg::wchan_t'(cbm_pkg::YEL_RG_WT))
			&& (blue_w < cbm_pkg::wchan_t'(pix_s1.pixel_green)
				* cbm_pkg::wchan_t'(cbm_pkg::YEL_RG_WT));
		hit_d.red    = kept && red_ok;
		hit_d.yellow = kept && yellow_ok;
		hit_d.last   = pix_s1.frame_end;
	end

	// Coordinates and squares for the moment sums.
	always_comb begin
		sample_d.x  = pix_s1.col;
		sample_d.y  = pix_s1.row;
		sample_d.xx = (2*cbm_pkg::COL_W)'(pix_s1.col) * (2*cbm_pkg::COL_W)'(pix_s1.col);
		sample_d.yy = (2*cbm_pkg::ROW_W)'(pix_s1.row) * (2*cbm_pkg::ROW_W)'(pix_s1.row);
	end

	// Classification register.
	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			hit_s2    <= hit_d;
			sample_s2 <= sample_d;
		end
	end

endmodule

FILE: rtl/cbm_class_acc.sv
//------------------------------------------------------------------------------
// Class accumulator
// Saturating count and moment sums of one color class, cleared at frame end.
//------------------------------------------------------------------------------
module cbm_class_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              consume,
	input  logic              hit,
	input  logic              clear,
	input  cbm_pkg::sample_t  sample,
	output cbm_pkg::acc_t     acc,
	output cbm_pkg::acc_t     acc_next
);

	typedef logic [cbm_pkg::CNT_W:0] cnt_ext_t;
	typedef logic [cbm_pkg::SUM_W:0] sum_ext_t;
	typedef logic [cbm_pkg::SQ_W:0]  sq_ext_t;

	cbm_pkg::acc_t acc_q;
	cnt_ext_t      tally_add;
	sum_ext_t      col_add;
	sum_ext_t      row_add;
	sq_ext_t       col_sq_add;
	sq_ext_t       row_sq_add;
	cbm_pkg::acc_t acc_add;

	// Saturating sums: a carry out pins the field at all ones.
	always_comb begin
		tally_add  = cnt_ext_t'(acc_q.tally) + cnt_ext_t'(1);
		col_add    = sum_ext_t'(acc_q.col_sum) + sum_ext_t'(sample.x);
		row_add    = sum_ext_t'(acc_q.row_sum) + sum_ext_t'(sample.y);
		col_sq_add = sq_ext_t'(acc_q.col_sq_sum) + sq_ext_t'(sample.xx);
		row_sq_add = sq_ext_t'(acc_q.row_sq_sum) + sq_ext_t'(sample.yy);
		acc_add.tally = tally_add[cbm_pkg::CNT_W] ? '1 : tally_add[cbm_pkg::CNT_W-1:0];
		acc_add.col_sum = col_add[cbm_pkg::SUM_W] ? '1 : col_add[cbm_pkg::SUM_W-1:0];
		acc_add.row_sum = row_add[cbm_pkg::SUM_W] ? '1 : row_add[cbm_pkg::SUM_W-1:0];
		acc_add.col_sq_sum = col_sq_add[cbm_pkg::SQ_W] ? '1
			: col_sq_add[cbm_pkg::SQ_W-1:0];
		acc_add.row_sq_sum = row_sq_add[cbm_pkg::SQ_W] ? '1
			: row_sq_add[cbm_pkg::SQ_W-1:0];
		acc_next = hit ? acc_add : acc_q;
	end

	// The frame-end pixel is folded in first; its totals leave through acc_next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (consume) begin
			acc_q <= clear ? '0 : acc_next;
		end
	end

	assign acc = acc_q;

	// A consumed frame end leaves the class empty.
	a_clear_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		consume && clear |=> acc_q == '0)
		else $error("class accumulator not cleared after frame end");

	// Sums only grow together with the count.
	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q.tally == '0 |-> acc_q.col_sum == '0 && acc_q.row_sum == '0
			&& acc_q.col_sq_sum == '0 && acc_q.row_sq_sum == '0)
		else $error("moment sums nonzero with empty count");

endmodule

FILE: rtl/color_blob_moment_accumulator.sv
//------------------------------------------------------------------------------
// Color blob moment accumulator
// Clips a pixel stream to a region and trapezoid, accumulates red and yellow
// class moments, and reports them with a verdict at each frame end.
//------------------------------------------------------------------------------
// The block takes one pixel per clock, back to back, as long as results are
// taken. A pixel passes an input register and a classification register and is
// then folded into the class accumulators. The result of a frame-end pixel is
// loaded into the output register at the same edge that folds that pixel in,
// and it sits in the output register until it is taken. Ordinary pixels keep
// flowing while a result waits; only the next frame-end pixel holds in the
// classification stage until the output register is free, and the input stalls
// behind it.
// Configuration writes take effect on the next pixel and are meant for idle
// periods between frames.
//------------------------------------------------------------------------------
module color_blob_moment_accumulator (
	input  logic                              clk,
	input  logic                              arst_n,
	cbm_pix_if.sink                           pix,
	cbm_res_if.source                         res,
	input  logic                              cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	cbm_pkg::cfg_t    cfg_q;
	cbm_pkg::cnt_t    min_total_q;
	logic             valid_s2;
	cbm_pkg::hit_t    hit_s2;
	cbm_pkg::sample_t sample_s2;
	logic             res_free;
	logic             adv;
	logic             res_load;
	cbm_pkg::acc_t    red_acc;
	cbm_pkg::acc_t    red_next;
	cbm_pkg::acc_t    yellow_acc;
	cbm_pkg::acc_t    yellow_next;
	logic [cbm_pkg::CNT_W:0] total;
	logic [1:0]       verdict_d;
	logic             res_valid_q;
	cbm_pkg::res_t    res_q;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_left     <= cbm_pkg::ROI_LEFT_RST;
			cfg_q.roi_top      <= cbm_pkg::ROI_TOP_RST;
			cfg_q.roi_width    <= cbm_pkg::ROI_WIDTH_RST;
			cfg_q.roi_height   <= cbm_pkg::ROI_HEIGHT_RST;
			cfg_q.red_floor    <= cbm_pkg::RED_FLOOR_RST;
			cfg_q.yellow_floor <= cbm_pkg::YELLOW_FLOOR_RST;
			min_total_q        <= cbm_pkg::MIN_TOTAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cbm_pkg::REG_ROI_LEFT: begin
					cfg_q.roi_left <= cfg_data[cbm_pkg::COL_W-1:0];
				end
				cbm_pkg::REG_ROI_TOP: begin
					cfg_q.roi_top <= cfg_data[cbm_pkg::ROW_W-1:0];
				end
				cbm_pkg::REG_ROI_WIDTH: begin
					cfg_q.roi_width <= cfg_data[cbm_pkg::COL_W-1:0];
				end
				cbm_pkg::REG_ROI_HEIGHT: begin
					cfg_q.roi_height <= cfg_data[cbm_pkg::COL_W-1:0];
				end
				cbm_pkg::REG_RED_FLOOR: begin
					cfg_q.red_floor <= cfg_data[cbm_pkg::CH_W-1:0];
				end
				cbm_pkg::REG_YELLOW_FLOOR: begin
					cfg_q.yellow_floor <= cfg_data[cbm_pkg::CH_W-1:0];
				end
				cbm_pkg::REG_MIN_TOTAL: begin
					min_total_q <= cfg_data[cbm_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front end: input register and classification.
	cbm_pixel_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.cfg       (cfg_q),
		.adv       (adv),
		.valid_s2  (valid_s2),
		.hit_s2    (hit_s2),
		.sample_s2 (sample_s2)
	);

	// A frame-end pixel needs the output register; other pixels never wait.
	assign res_free = !res_valid_q || res.ready;
	assign adv      = valid_s2 && (!hit_s2.last || res_free);
	assign res_load = adv && hit_s2.last;

	cbm_class_acc u_red_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.consume  (adv),
		.hit      (hit_s2.red),
		.clear    (hit_s2.last),
		.sample   (sample_s2),
		.acc      (red_acc),
		.acc_next (red_next)
	);

	cbm_class_acc u_yellow_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.consume  (adv),
		.hit      (hit_s2.yellow),
		.clear    (hit_s2.last),
		.sample   (sample_s2),
		.acc      (yellow_acc),
		.acc_next (yellow_next)
	);

	// Verdict: too few pixels in total gives none, ties go to yellow.
	always_comb begin
		total = {1'b0, red_next.tally} + {1'b0, yellow_next.tally};
		if (total < {1'b0, min_total_q}) begin
			verdict_d = cbm_pkg::VERDICT_NONE;
		end else if (red_next.tally > yellow_next.tally) begin
			verdict_d = cbm_pkg::VERDICT_RED;
		end else begin
			verdict_d = cbm_pkg::VERDICT_YELLOW;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.verdict       <= verdict_d;
			res_q.red_count     <= red_next.tally;
			res_q.red_sum_x     <= red_next.col_sum;
			res_q.red_sum_y     <= red_next.row_sum;
			res_q.red_sum_xx    <= red_next.col_sq_sum;
			res_q.red_sum_yy    <= red_next.row_sq_sum;
			res_q.yellow_count  <= yellow_next.tally;
			res_q.yellow_sum_x  <= yellow_next.col_sum;
			res_q.yellow_sum_y  <= yellow_next.row_sum;
			res_q.yellow_sum_xx <= yellow_next.col_sq_sum;
			res_q.yellow_sum_yy <= yellow_next.row_sq_sum;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// A consumed frame end always shows up as a pending result.
	a_result_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> res_valid_q)
		else $error("frame end consumed without a result");

	// Red verdict only with a strict red majority.
	a_red_majority: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.verdict == cbm_pkg::VERDICT_RED
			|-> res_q.red_count > res_q.yellow_count)
		else $error("red verdict without red majority");

	// Yellow verdict only when yellow at least ties red.
	a_yellow_majority: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.verdict == cbm_pkg::VERDICT_YELLOW
			|-> res_q.yellow_count >= res_q.red_count)
		else $error("yellow verdict with red majority");

	// Both classes clear together with the frame end.
	a_classes_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> red_acc.tally == '0 && yellow_acc.tally == '0)
		else $error("class counts survive a frame end");

endmodule
